FILE: hdl/mas_pkg.sv
`default_nettype none

package mas_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIM_W      = IDX_W + 1;
  localparam int MODE_W     = 2;
  localparam int OPER_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = DIM_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OPER_W-1:0] OPER_WR_A  = 2'd0;
  localparam logic [OPER_W-1:0] OPER_WR_B  = 2'd1;
  localparam logic [OPER_W-1:0] OPER_QUERY = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

  typedef enum logic [2:0] {
    KIND_WR_A,
    KIND_WR_B,
    KIND_ERR,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [DATA_W-1:0]  value;
    logic [DIM_W-1:0]   len;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BST_IDLE,
    BST_ARD,
    BST_MUL,
    BST_DONE
  } bst_t;

endpackage

`default_nettype wire

FILE: hdl/mas_front.sv
`default_nettype none

module mas_front import mas_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic [OPER_W-1:0]       in_operation,
  input  wire logic [IDX_W-1:0]        in_row,
  input  wire logic [IDX_W-1:0]        in_col,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire q_status_t               q_stat,
  output      logic                    push,
  output      entry_t                  push_entry
);

  logic [MODE_W-1:0] op_mode_r;
  logic [DIM_W-1:0]  rows_a_r;
  logic [DIM_W-1:0]  cols_a_r;
  logic [DIM_W-1:0]  rows_b_r;
  logic [DIM_W-1:0]  cols_b_r;

  logic [DIM_W-1:0]  row_ext;
  logic [DIM_W-1:0]  col_ext;
  logic              err_addsub;
  logic              err_mul;
  logic              query_err;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_ADD;
      rows_a_r  <= DIM_ONE;
      cols_a_r  <= DIM_ONE;
      rows_b_r  <= DIM_ONE;
      cols_b_r  <= DIM_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OP_MODE: op_mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_ROWS_A:  rows_a_r  <= cfg_wdata;
        CFG_COLS_A:  cols_a_r  <= cfg_wdata;
        CFG_ROWS_B:  rows_b_r  <= cfg_wdata;
        CFG_COLS_B:  cols_b_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign row_ext = {1'b0, in_row};
  assign col_ext = {1'b0, in_col};

  assign err_addsub = (rows_a_r != rows_b_r) || (cols_a_r != cols_b_r) ||
                      (rows_a_r > DIM_MAX) || (cols_a_r > DIM_MAX) ||
                      (row_ext >= rows_a_r) || (col_ext >= cols_a_r);

  assign err_mul = (cols_a_r != rows_b_r) || (rows_a_r > DIM_MAX) ||
                   (cols_a_r > DIM_MAX) || (cols_b_r > DIM_MAX) ||
                   (row_ext >= rows_a_r) || (col_ext >= cols_b_r);

  always_comb begin
    case (op_mode_r)
      MODE_ADD, MODE_SUB: query_err = err_addsub;
      MODE_MUL:           query_err = err_mul;
      default:            query_err = 1'b1;
    endcase
  end

  assign in_stall = q_stat.full;

  always_comb begin
    push_entry.row   = in_row;
    push_entry.col   = in_col;
    push_entry.value = in_value;
    push_entry.len   = cols_a_r;
    push_entry.kind  = KIND_ERR;
    push             = 1'b0;
    case (in_operation)
      OPER_WR_A: begin
        push_entry.kind = KIND_WR_A;
        push            = in_valid && !q_stat.full;
      end
      OPER_WR_B: begin
        push_entry.kind = KIND_WR_B;
        push            = in_valid && !q_stat.full;
      end
      OPER_QUERY: begin
        if (query_err) begin
          push_entry.kind = KIND_ERR;
        end else if (op_mode_r == MODE_MUL) begin
          push_entry.kind = KIND_MUL;
        end else if (op_mode_r == MODE_SUB) begin
          push_entry.kind = KIND_SUB;
        end else begin
          push_entry.kind = KIND_ADD;
        end
        push = in_valid && !q_stat.full;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/mas_queue.sv
`default_nettype none

module mas_queue import mas_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output      entry_t head,
  output      q_status_t q_stat
);

  entry_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic [QUEUE_CW-1:0] count_nxt;

  localparam logic [QUEUE_CW-1:0] COUNT_FULL = QUEUE_CW'(QUEUE_DEPTH);
  localparam logic [QUEUE_CW-1:0] COUNT_ONE  = QUEUE_CW'(1);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + COUNT_ONE;
    end else if (pop && !push) begin
      count_nxt = count_r - COUNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == COUNT_FULL);

endmodule

`default_nettype wire

FILE: hdl/mas_back.sv
`default_nettype none

module mas_back import mas_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire entry_t                   head,
  input  wire q_status_t                q_stat,
  output      logic                     pop,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic signed [DATA_W-1:0] out_result,
  output      logic                     out_error
);

  logic [DATA_W-1:0] mem_a [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] mem_b [MAX_DIM*MAX_DIM];

  bst_t              state_r, state_nxt;
  entry_t            ent_r, ent_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic              rdv_r, rdv_nxt;
  logic              prodv_r;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_result_r, out_result_nxt;
  logic              out_error_r, out_error_nxt;

  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic              wr_en_a, wr_en_b;

  assign wr_addr = {head.row, head.col};

  always_comb begin
    state_nxt      = state_r;
    ent_nxt        = ent_r;
    k_nxt          = k_r;
    rdv_nxt        = 1'b0;
    acc_nxt        = acc_r;
    pop            = 1'b0;
    wr_en_a        = 1'b0;
    wr_en_b        = 1'b0;
    rd_addr_a      = {head.row, head.col};
    rd_addr_b      = {head.row, head.col};
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    case (state_r)
      BST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.kind)
            KIND_WR_A: wr_en_a = 1'b1;
            KIND_WR_B: wr_en_b = 1'b1;
            KIND_ADD, KIND_SUB: begin
              ent_nxt   = head;
              state_nxt = BST_ARD;
            end
            KIND_MUL: begin
              ent_nxt   = head;
              k_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = BST_MUL;
            end
            default: begin
              ent_nxt   = head;
              acc_nxt   = '0;
              state_nxt = BST_DONE;
            end
          endcase
        end
      end
      BST_ARD: begin
        acc_nxt   = (ent_r.kind == KIND_SUB) ? rd_a_r - rd_b_r : rd_a_r + rd_b_r;
        state_nxt = BST_DONE;
      end
      BST_MUL: begin
        rd_addr_a = {ent_r.row, k_r[IDX_W-1:0]};
        rd_addr_b = {k_r[IDX_W-1:0], ent_r.col};
        if (prodv_r) begin
          acc_nxt = acc_r + prod_r;
        end
        if (k_r != ent_r.len) begin
          rdv_nxt = 1'b1;
          k_nxt   = k_r + DIM_W'(1);
        end else if (!rdv_r && !prodv_r) begin
          state_nxt = BST_DONE;
        end
      end
      BST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_error_nxt  = (ent_r.kind == KIND_ERR);
          state_nxt      = BST_IDLE;
        end
      end
      default: state_nxt = BST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BST_IDLE;
      rdv_r       <= 1'b0;
      prodv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rdv_r       <= rdv_nxt;
      prodv_r     <= rdv_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r        <= ent_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= rd_a_r * rd_b_r;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en_a) begin
      mem_a[wr_addr] <= head.value;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_en_b) begin
      mem_b[wr_addr] <= head.value;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule

`default_nettype wire

FILE: hdl/matrix_add_sub_mul_unit_core.sv
`default_nettype none

// Integer matrix add / subtract / multiply unit. Elements of A and B are
// written one beat at a time into two 64x64 word stores; a query beat returns
// one element of A+B, A-B or A*B (mode and dimensions set over the cfg port;
// the user must write them only while the unit is idle; the block does not
// enforce it), with error set and result 0 when the dimensions do not fit the
// mode or the position lies outside the result. Writes retire at one per
// cycle while no query is executing. An add or subtract query reads both
// stores, then adds or subtracts them; a multiply query walks k over cols_a,
// paced by each store's single read port and the one multiply-accumulate
// unit that sums one product per cycle. A two-entry queue between the input
// and execution sides lets input beats be taken while a query is in progress.
// Store entries read before they are written return unspecified data.

module matrix_add_sub_mul_unit_core import mas_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [OPER_W-1:0]        in_operation,
  input  wire logic [IDX_W-1:0]         in_row,
  input  wire logic [IDX_W-1:0]         in_col,
  input  wire logic signed [DATA_W-1:0] in_value,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic signed [DATA_W-1:0] out_result,
  output      logic                     out_error
);

  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;
  q_status_t q_stat;

  mas_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  mas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .out_error  (out_error)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_result == '0))
    else $error("error beat with nonzero result");
`endif

endmodule

`default_nettype wire

FILE: test/tb_matrix_add_sub_mul_unit_core.sv
`timescale 1ns / 1ps

module tb_matrix_add_sub_mul_unit_core;
  import mas_pkg::*;

  localparam logic [OPER_W-1:0] OPER_NONE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              flag;
  } element_t;

  class element_checker;
    logic [MODE_W-1:0] mode = MODE_ADD;
    logic [DIM_W-1:0]  rows_a = 1;
    logic [DIM_W-1:0]  cols_a = 1;
    logic [DIM_W-1:0]  rows_b = 1;
    logic [DIM_W-1:0]  cols_b = 1;
    logic [DATA_W-1:0] a_mem [0:MAX_DIM*MAX_DIM-1];
    logic [DATA_W-1:0] b_mem [0:MAX_DIM*MAX_DIM-1];
    element_t          pending_elements [$];
    int                errors = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_OP_MODE: mode = data[MODE_W-1:0];
        CFG_ROWS_A: rows_a = data;
        CFG_COLS_A: cols_a = data;
        CFG_ROWS_B: rows_b = data;
        CFG_COLS_B: cols_b = data;
        default: ;
      endcase
    endfunction

    function void element_value(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                output logic [DATA_W-1:0] v, output logic err);
      logic [DATA_W-1:0] acc;
      v = '0;
      err = 1'b1;
      acc = '0;
      if (mode == MODE_ADD || mode == MODE_SUB) begin
        if (rows_a == rows_b && cols_a == cols_b && rows_a <= MAX_DIM && cols_a <= MAX_DIM &&
            r < rows_a && c < cols_a) begin
          err = 1'b0;
          if (mode == MODE_ADD) v = a_mem[{r, c}] + b_mem[{r, c}];
          else v = a_mem[{r, c}] - b_mem[{r, c}];
        end
      end else if (mode == MODE_MUL) begin
        if (cols_a == rows_b && rows_a <= MAX_DIM && cols_a <= MAX_DIM && cols_b <= MAX_DIM &&
            r < rows_a && c < cols_b) begin
          err = 1'b0;
          for (int k = 0; k < cols_a; k++)
            acc = acc + a_mem[{r, k[IDX_W-1:0]}] * b_mem[{k[IDX_W-1:0], c}];
          v = acc;
        end
      end
    endfunction

    function void note_input(logic [OPER_W-1:0] op, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
      element_t want;
      case (op)
        OPER_WR_A: a_mem[{r, c}] = v;
        OPER_WR_B: b_mem[{r, c}] = v;
        OPER_QUERY: begin
          element_value(r, c, want.value, want.flag);
          pending_elements.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_elements.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [DATA_W-1:0] res, logic err);
      element_t want;
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected beat result=%08h error=%0b", res, err));
        return;
      end
      want = pending_elements.pop_front();
      if (res !== want.value)
        report_mismatch($sformatf("result %08h, want %08h", res, want.value));
      if (err !== want.flag)
        report_mismatch($sformatf("error %0b, want %0b", err, want.flag));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [OPER_W-1:0]        in_operation;
  logic [IDX_W-1:0]         in_row;
  logic [IDX_W-1:0]         in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_result;
  logic                     out_error;

  element_checker board = new;
  bit wa [0:MAX_DIM*MAX_DIM-1];
  bit wb [0:MAX_DIM*MAX_DIM-1];
  bit send_idle = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;
  int items = 0;
  int quiet = 0;

  matrix_add_sub_mul_unit_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_row(in_row),
    .in_col(in_col),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result(out_result),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int span(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [OPER_W-1:0] op, logic [IDX_W-1:0] r,
                           logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = op;
    in_row = r;
    in_col = c;
    in_value = v;
    do @(posedge clk); while (in_stall);
    board.note_input(op, r, c, v);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  task automatic issue(logic [OPER_W-1:0] op, logic [IDX_W-1:0] r,
                       logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
    if (op == OPER_WR_A) wa[{r, c}] = 1'b1;
    if (op == OPER_WR_B) wb[{r, c}] = 1'b1;
    if (op != OPER_NONE) items++;
    send_item(op, r, c, v);
  endtask

  task automatic fill_operands(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    if (board.mode == MODE_MUL) begin
      for (int k = 0; k < board.cols_a; k++) begin
        if (!wa[{r, k[IDX_W-1:0]}]) issue(OPER_WR_A, r, k[IDX_W-1:0], rand_value());
        if (!wb[{k[IDX_W-1:0], c}]) issue(OPER_WR_B, k[IDX_W-1:0], c, rand_value());
      end
    end else begin
      if (!wa[{r, c}]) issue(OPER_WR_A, r, c, rand_value());
      if (!wb[{r, c}]) issue(OPER_WR_B, r, c, rand_value());
    end
  endtask

  task automatic random_item();
    int p;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [DATA_W-1:0] v;
    logic e;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      issue(OPER_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    end else if (p < 29) begin
      r = (p < 24) ? IDX_W'($urandom_range(0, span(board.rows_a) - 1)) : IDX_W'($urandom);
      c = (p < 24) ? IDX_W'($urandom_range(0, span(board.cols_a) - 1)) : IDX_W'($urandom);
      issue(OPER_WR_A, r, c, rand_value());
    end else if (p < 50) begin
      r = (p < 45) ? IDX_W'($urandom_range(0, span(board.rows_b) - 1)) : IDX_W'($urandom);
      c = (p < 45) ? IDX_W'($urandom_range(0, span(board.cols_b) - 1)) : IDX_W'($urandom);
      issue(OPER_WR_B, r, c, rand_value());
    end else begin
      r = (p < 92) ? IDX_W'($urandom_range(0, span(board.rows_a) - 1)) : IDX_W'($urandom);
      if (p >= 92) c = IDX_W'($urandom);
      else if (board.mode == MODE_MUL) c = IDX_W'($urandom_range(0, span(board.cols_b) - 1));
      else c = IDX_W'($urandom_range(0, span(board.cols_a) - 1));
      board.element_value(r, c, v, e);
      if (!e) fill_operands(r, c);
      issue(OPER_QUERY, r, c, $urandom);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic run_phase(logic [MODE_W-1:0] mode, logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ca,
                           logic [DIM_W-1:0] rb, logic [DIM_W-1:0] cb, int n);
    logic [CFG_W-1:0] mode_word;
    int start;
    settle();
    mode_word = CFG_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    write_reg(CFG_OP_MODE, mode_word);
    write_reg(CFG_ROWS_A, ra);
    write_reg(CFG_COLS_A, ca);
    write_reg(CFG_ROWS_B, rb);
    write_reg(CFG_COLS_B, cb);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    start = items;
    while (items - start < n) random_item();
  endtask

  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      board.check_result(out_result, out_error);
  end

  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0] m;
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] ca;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operation = OPER_WR_A;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue(OPER_WR_A, 6'd0, 6'd0, 32'h7fff_ffff);
    issue(OPER_WR_B, 6'd0, 6'd0, 32'h0000_0001);
    issue(OPER_QUERY, 6'd0, 6'd0, 32'hffff_ffff);
    issue(OPER_WR_A, 6'd63, 6'd63, 32'h8000_0000);
    issue(OPER_WR_B, 6'd63, 6'd63, 32'hffff_ffff);
    issue(OPER_QUERY, 6'd63, 6'd63, 32'h0000_0000);
    issue(OPER_QUERY, 6'd0, 6'd63, 32'h8000_0000);
    issue(OPER_QUERY, 6'd63, 6'd0, 32'h7fff_ffff);
    issue(OPER_NONE, 6'd63, 6'd63, 32'hffff_ffff);
    issue(OPER_NONE, 6'd0, 6'd0, 32'h0000_0000);
    run_phase(MODE_SUB, 1, 1, 1, 1, 0);
    issue(OPER_QUERY, 6'd0, 6'd0, 32'h0);
    run_phase(MODE_MUL, 1, 1, 1, 1, 0);
    issue(OPER_QUERY, 6'd0, 6'd0, 32'h0);
    issue(OPER_QUERY, 6'd1, 6'd0, 32'h0);

    run_phase(MODE_ADD, 4, 4, 4, 4, 60);
    run_phase(MODE_SUB, 3, 5, 3, 5, 60);
    run_phase(MODE_MUL, 3, 4, 4, 2, 80);
    run_phase(MODE_ADD, 2, 3, 3, 2, 20);
    run_phase(MODE_MUL, 2, 3, 2, 3, 20);
    run_phase(MODE_MUL, 0, 1, 1, 1, 15);
    run_phase(MODE_SUB, 2, 0, 2, 0, 15);
    run_phase(MODE_ADD, 65, 65, 65, 65, 15);
    run_phase(MODE_MUL, 2, 127, 127, 2, 15);
    run_phase(MODE_BAD, 4, 4, 4, 4, 15);
    run_phase(MODE_MUL, 64, 64, 64, 64, 60);
    run_phase(MODE_ADD, 64, 64, 64, 64, 40);
    run_phase(MODE_MUL, 1, 64, 64, 1, 40);

    send_idle = 1'b0;
    run_phase(MODE_MUL, 5, 3, 3, 6, 10);
    hold_req = 1'b1;
    repeat (140) random_item();
    send_idle = 1'b1;

    repeat (6) begin
      m = MODE_W'($urandom_range(0, 2));
      ra = DIM_W'($urandom_range(1, 6));
      ca = DIM_W'($urandom_range(1, 6));
      if ($urandom_range(0, 4) == 0)
        run_phase(m, ra, ca, DIM_W'($urandom_range(1, 6)), DIM_W'($urandom_range(1, 6)), 60);
      else if (m == MODE_MUL)
        run_phase(m, ra, ca, ca, DIM_W'($urandom_range(1, 6)), 60);
      else
        run_phase(m, ra, ca, ra, ca, 60);
    end

    send_idle = 1'b0;
    stall_on = 1'b0;
    run_phase(MODE_MUL, 4, 4, 4, 4, 100);

    settle();
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: matrix_add_sub_mul_unit_core.f
hdl/mas_pkg.sv
hdl/mas_front.sv
hdl/mas_queue.sv
hdl/mas_back.sv
hdl/matrix_add_sub_mul_unit_core.sv
test/tb_matrix_add_sub_mul_unit_core.sv
